// File: rtl/core/aema_pkg.sv
// Package for the adaptive EMA accumulator: field widths, register indexes,
// reset values and default parameter values. No dependencies.
package aema_pkg;

	// Default parameter values
	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF    = 16;

	// Field widths of the channels
	localparam int FIELD_W    = 32;
	localparam int POSITION_W = 16;
	localparam int WINDOW_W   = 16;
	localparam int ALPHA_W    = 17;
	localparam int DIV_NUM_W  = ALPHA_W + 1;

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ALPHA = CFG_IDX_W'(1);

	// Q1.16 smoothing factor constants
	localparam logic [ALPHA_W-1:0]  ALPHA_ONE    = ALPHA_W'(65536);
	localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = ALPHA_W'(19661);
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(1);

	// Step counts of the iterative unit
	localparam int DIV_STEPS = DIV_NUM_W;
	localparam int MUL_STEPS = ALPHA_W;
	localparam int CNT_W     = 5;

	// Saturate an 18-bit quotient or a register value to 1.0
	function automatic logic [ALPHA_W-1:0] sat_alpha(input logic [DIV_NUM_W-1:0] a);
		logic [ALPHA_W-1:0] r;
		if (a > DIV_NUM_W'(ALPHA_ONE)) begin
			r = ALPHA_ONE;
		end else begin
			r = a[ALPHA_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/aema_ifs.sv
// Channel interfaces of the adaptive EMA accumulator: sample items,
// average results and configuration writes. Depends on aema_pkg.

interface aema_item_if import aema_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [FIELD_W-1:0]    sample;
	logic                  has_sample;
	logic [POSITION_W-1:0] position;
	logic                  finish;

	modport source (output valid, sample, has_sample, position, finish, input ready);
	modport sink   (input valid, sample, has_sample, position, finish, output ready);
endinterface

interface aema_result_if import aema_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] average;

	modport source (output valid, average, input ready);
	modport sink   (input valid, average, output ready);
endinterface

interface aema_cfg_if import aema_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/adaptive_ema_accumulator_unit.sv
// Adaptive EMA accumulator. Finish request: result registered in the cycle after
// accept. Seeding sample: loaded into the average at accept. Later sample: difference,
// 17 shift-add steps on the shared adder, rounding, update; when position 1 reloads
// alpha, a restoring divider on the same adder runs first. All steps use that adder.
// Reset (arst_n low): average 0, unseeded, alpha 0.3, window length 1.
// Depends on aema_pkg and aema_ifs.
module adaptive_ema_accumulator_unit import aema_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	aema_item_if.sink     item,
	aema_result_if.source result,
	aema_cfg_if.sink      cfg
);

	// Average format and unit widths
	localparam int AF    = (SAMPLE_WIDTH + FRAC_BITS <= 64) ? FRAC_BITS : 64 - SAMPLE_WIDTH;
	localparam int AW    = SAMPLE_WIDTH + AF;
	localparam int MW    = AW + ALPHA_W;
	localparam int RW    = SAMPLE_WIDTH + 1;
	localparam int OUT_W = (SAMPLE_WIDTH < FIELD_W) ? SAMPLE_WIDTH : FIELD_W;

	// Sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_DIFF = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_RND  = 3'd4;
	localparam logic [2:0] ST_UPD  = 3'd5;

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  seeded_q;
	logic [AW-1:0]         avg_q;
	logic [ALPHA_W-1:0]    alpha_q;
	logic [WINDOW_W-1:0]   wl_q;
	logic                  out_valid_q;
	logic [FIELD_W-1:0]    out_q;

	logic [AW-1:0]         x_q;
	logic                  ge_q;
	logic [AW-1:0]         d_q;
	logic [MW-1:0]         acc_q;
	logic [ALPHA_W-1:0]    mula_q;
	logic [ALPHA_W-1:0]    rem_q;
	logic [DIV_NUM_W-1:0]  num_q;
	logic [DIV_NUM_W-1:0]  quo_q;

	logic                  in_fire;
	logic [SAMPLE_WIDTH-1:0] sample_w;
	logic [AW-1:0]         x_new;
	logic [ALPHA_W-1:0]    n1;
	logic [DIV_NUM_W-1:0]  rem_sh;
	logic [DIV_NUM_W-1:0]  quo_next;
	logic [AW-1:0]         step;
	logic [RW-1:0]         rnd;
	logic [FIELD_W-1:0]    avg_sat;

	// Shared adder/subtractor
	logic [MW-1:0]         unit_a;
	logic [MW-1:0]         unit_b;
	logic                  unit_sub;
	logic [MW:0]           unit_res;
	logic                  unit_carry;

	assign item.ready = (state_q == ST_IDLE) && (!out_valid_q || result.ready);
	assign in_fire    = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	assign result.valid   = out_valid_q;
	assign result.average = out_q;

	// Sample in the average's format
	assign sample_w = SAMPLE_WIDTH'(item.sample);
	assign x_new    = AW'(sample_w) << AF;

	// Window plus one and the divider's shifted remainder
	assign n1       = ALPHA_W'(wl_q) + ALPHA_W'(1);
	assign rem_sh   = {rem_q, num_q[DIV_NUM_W-1]};
	assign quo_next = {quo_q[DIV_NUM_W-2:0], unit_carry};

	// Rounded step: (acc + 2^15) already held in acc_q at the update state
	assign step = AW'(acc_q >> 16);

	// Operand selection for the shared adder
	always_comb begin
		unit_a   = '0;
		unit_b   = '0;
		unit_sub = 1'b0;
		case (state_q)
			ST_DIV: begin
				unit_a   = MW'(rem_sh);
				unit_b   = MW'(n1);
				unit_sub = 1'b1;
			end
			ST_DIFF: begin
				unit_a   = ge_q ? MW'(x_q) : MW'(avg_q);
				unit_b   = ge_q ? MW'(avg_q) : MW'(x_q);
				unit_sub = 1'b1;
			end
			ST_MUL: begin
				unit_a = acc_q << 1;
				unit_b = mula_q[ALPHA_W-1] ? MW'(d_q) : '0;
			end
			ST_RND: begin
				unit_a = acc_q;
				unit_b = MW'(32'h8000);
			end
			ST_UPD: begin
				unit_a   = MW'(avg_q);
				unit_b   = MW'(step);
				unit_sub = !ge_q;
			end
			default: begin
				unit_sub = 1'b0;
			end
		endcase
	end

	assign unit_res   = {1'b0, unit_a} + {1'b0, unit_sub ? ~unit_b : unit_b}
		+ (MW+1)'(unit_sub);
	assign unit_carry = unit_res[MW];

	// Round to nearest, ties up
	generate
		if (AF == 0) begin : g_rnd_int
			assign rnd = RW'(avg_q);
		end else begin : g_rnd_frac
			assign rnd = RW'(avg_q >> AF) + RW'(avg_q[AF-1]);
		end
	endgenerate

	// Saturate to the sample range and the 32-bit field
	assign avg_sat = ((rnd >> OUT_W) != '0) ? FIELD_W'({OUT_W{1'b1}})
		: FIELD_W'(rnd[OUT_W-1:0]);

	// Control state, configuration and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			seeded_q    <= 1'b0;
			avg_q       <= '0;
			alpha_q     <= ALPHA_RESET;
			wl_q        <= WINDOW_RESET;
			out_valid_q <= 1'b0;
		end else begin
			// Configuration writes
			if (cfg.valid) begin
				case (cfg.index)
					REG_WINDOW_LENGTH: wl_q <= cfg.data[WINDOW_W-1:0];
					REG_DEFAULT_ALPHA: alpha_q <= sat_alpha(DIV_NUM_W'(cfg.data));
					default: wl_q <= wl_q;
				endcase
			end

			// Result register
			if (in_fire && item.finish) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_fire && !item.finish && item.has_sample) begin
						if (!seeded_q) begin
							avg_q    <= x_new;
							seeded_q <= 1'b1;
						end else if (item.position == POSITION_W'(1)) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_DIFF;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						alpha_q <= sat_alpha(quo_next);
						cnt_q   <= '0;
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					avg_q   <= unit_res[AW-1:0];
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_fire && item.finish) begin
			out_q <= avg_sat;
		end
		case (state_q)
			ST_IDLE: begin
				x_q   <= x_new;
				ge_q  <= x_new >= avg_q;
				rem_q <= '0;
				quo_q <= '0;
				num_q <= {1'b1, 1'b0, n1[ALPHA_W-1:1]};
			end
			ST_DIV: begin
				rem_q <= unit_carry ? unit_res[ALPHA_W-1:0] : rem_sh[ALPHA_W-1:0];
				quo_q <= quo_next;
				num_q <= num_q << 1;
			end
			ST_DIFF: begin
				d_q    <= unit_res[AW-1:0];
				acc_q  <= '0;
				mula_q <= alpha_q;
			end
			ST_MUL: begin
				acc_q  <= unit_res[MW-1:0];
				mula_q <= mula_q << 1;
			end
			ST_RND: begin
				acc_q <= unit_res[MW-1:0];
			end
			default: begin
				mula_q <= mula_q;
			end
		endcase
	end

endmodule

// File: tb/tb_adaptive_ema_accumulator_unit.sv
// Self-checking testbench for adaptive_ema_accumulator_unit: random and directed
// sample/finish requests, register writes between phases, scoreboard predictor.
// Depends on aema_pkg and the channel interfaces in aema_ifs.
module tb_adaptive_ema_accumulator_unit import aema_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int AVG_FRAC = 16;
	localparam int AVG_W = 32 + AVG_FRAC;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = '1;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 175;

	// Tracks the block's state and holds the averages still owed by it
	class average_board;
		logic [WINDOW_W-1:0] window_len;
		logic [ALPHA_W-1:0]  alpha;
		logic [AVG_W-1:0]    avg;
		bit                  seeded;
		logic [FIELD_W-1:0]  pending_averages[$];
		int                  mismatches;

		function new();
			window_len = WINDOW_RESET;
			alpha = ALPHA_RESET;
			avg = '0;
			seeded = 0;
			mismatches = 0;
		endfunction

		function logic [ALPHA_W-1:0] clamp_alpha(logic [ALPHA_W:0] a);
			if (a > (ALPHA_W+1)'(ALPHA_ONE)) begin
				return ALPHA_ONE;
			end
			return a[ALPHA_W-1:0];
		endfunction

		// Round to nearest, ties up, clipped to the field
		function logic [FIELD_W-1:0] rounded_average();
			logic [FIELD_W:0] r;
			r = {1'b0, avg[AVG_W-1:AVG_FRAC]} + (FIELD_W+1)'(avg[AVG_FRAC-1]);
			if (r[FIELD_W]) begin
				return '1;
			end
			return r[FIELD_W-1:0];
		endfunction

		function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_WINDOW_LENGTH: window_len = data[WINDOW_W-1:0];
				REG_DEFAULT_ALPHA: alpha = clamp_alpha({1'b0, data[ALPHA_W-1:0]});
				default: ;
			endcase
		endfunction

		function void note_request(logic [FIELD_W-1:0] sample, logic has_sample,
				logic [POSITION_W-1:0] position, logic finish);
			logic [AVG_W-1:0]     x;
			logic [AVG_W-1:0]     d;
			logic [AVG_W-1:0]     step;
			logic [AVG_W+ALPHA_W:0] prod;
			logic [ALPHA_W-1:0]   n1;
			logic [ALPHA_W:0]     quot;
			if (finish) begin
				pending_averages.push_back(rounded_average());
				return;
			end
			if (!has_sample) begin
				return;
			end
			x = {sample, {AVG_FRAC{1'b0}}};
			if (!seeded) begin
				avg = x;
				seeded = 1;
				return;
			end
			// position 1 reloads alpha = 2/(N+1)
			if (position == POSITION_W'(1)) begin
				n1 = {1'b0, window_len} + ALPHA_W'(1);
				quot = ((ALPHA_W+1)'(131072) + (ALPHA_W+1)'(n1 >> 1)) / (ALPHA_W+1)'(n1);
				alpha = clamp_alpha(quot);
			end
			d = (x >= avg) ? x - avg : avg - x;
			prod = (AVG_W+ALPHA_W+1)'(d) * (AVG_W+ALPHA_W+1)'(alpha)
				+ (AVG_W+ALPHA_W+1)'(32768);
			step = prod[AVG_W+AVG_FRAC-1:AVG_FRAC];
			avg = (x >= avg) ? avg + step : avg - step;
		endfunction

		function void check_average(logic [FIELD_W-1:0] actual);
			logic [FIELD_W-1:0] want;
			if (pending_averages.size() == 0) begin
				if (mismatches < 10) begin
					$display("unexpected average %0d at %0t", actual, $realtime);
				end
				mismatches++;
				return;
			end
			want = pending_averages.pop_front();
			if (actual !== want) begin
				if (mismatches < 10) begin
					$display("average mismatch at %0t: expected %0d, got %0d",
						$realtime, want, actual);
				end
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	aema_item_if   item ();
	aema_result_if result ();
	aema_cfg_if    cfg ();

	average_board board;
	bit no_gaps;
	bit hold_request;

	adaptive_ema_accumulator_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Observe accepted requests, results and register writes
	always @(posedge clk) begin
		if (arst_n && item.valid && item.ready) begin
			board.note_request(item.sample, item.has_sample, item.position, item.finish);
		end
		if (arst_n && result.valid && result.ready) begin
			board.check_average(result.average);
		end
		if (arst_n && cfg.valid && cfg.ready) begin
			board.note_write(cfg.index, cfg.data);
		end
	end

	// Result receiver: random stalls, one long hold-off on request
	initial begin
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 0;
			end else begin
				result.ready <= no_gaps || ($urandom_range(99) >= 13);
			end
		end
	end

	task automatic offer_request(input logic [FIELD_W-1:0] s, input logic h,
			input logic [POSITION_W-1:0] p, input logic f);
		item.valid <= 1'b1;
		item.sample <= s;
		item.has_sample <= h;
		item.position <= p;
		item.finish <= f;
		do @(posedge clk); while (!item.ready);
		if (!no_gaps && $urandom_range(99) < 13) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	// Wait until every owed average has come, then let sample updates finish
	task automatic drain();
		item.valid <= 1'b0;
		@(posedge clk);
		while (board.pending_averages.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [FIELD_W-1:0] pick_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return FIELD_W'($urandom);
		endcase
	endfunction

	// Mostly well-formed samples and finishes, some ignored noise
	task automatic random_request(input int finish_pct, output bit counted);
		int                    roll;
		logic [FIELD_W-1:0]    s;
		logic [POSITION_W-1:0] p;
		logic                  h;
		logic                  f;
		roll = $urandom_range(99);
		s = pick_sample();
		p = ($urandom_range(7) == 0) ? POSITION_W'(1) : POSITION_W'($urandom_range(65535));
		counted = 1;
		if (roll < 8) begin
			h = 1'b0;
			f = 1'b0;
			counted = 0;
		end else if (roll < 8 + finish_pct) begin
			h = 1'(($urandom_range(1)));
			f = 1'b1;
		end else begin
			h = 1'b1;
			f = 1'b0;
		end
		offer_request(s, h, p, f);
	endtask

	initial begin
		int unsigned phase_window[6];
		int unsigned phase_alpha[6];
		int          done;
		bit          counted;

		phase_window = '{10, 0, 65535, 1, 3, 255};
		phase_alpha = '{19661, 65536, 0, 131071, 40000, 0};
		phase_alpha[5] = $urandom_range(131071);
		board = new();
		no_gaps = 0;
		hold_request = 0;
		arst_n <= 1'b0;
		item.valid <= 1'b0;
		item.sample <= '0;
		item.has_sample <= 1'b0;
		item.position <= '0;
		item.finish <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings
		offer_request(32'd0, 1'b0, 16'd0, 1'b1);          // finish before any sample
		offer_request('1, 1'b0, 16'd1, 1'b0);             // ignored item
		offer_request('1, 1'b1, 16'd1, 1'b0);             // seed, position ignored
		offer_request(32'd0, 1'b0, 16'd0, 1'b1);
		offer_request(32'd0, 1'b1, 16'hFFFF, 1'b0);
		offer_request(32'd123, 1'b1, 16'd1, 1'b1);        // finish ignores sample fields
		offer_request(32'd0, 1'b1, 16'd1, 1'b0);          // reload alpha from window 1
		offer_request(32'd0, 1'b0, 16'd0, 1'b1);
		offer_request('1, 1'b1, 16'd2, 1'b0);
		offer_request(32'd0, 1'b0, 16'd0, 1'b1);
		offer_request(32'h8000_0000, 1'b1, 16'd0, 1'b0);
		offer_request(32'd0, 1'b0, 16'd0, 1'b1);
		offer_request(32'd1, 1'b1, 16'hFFFE, 1'b0);
		offer_request(32'd0, 1'b0, 16'd0, 1'b1);
		offer_request(32'h7FFF_FFFF, 1'b1, 16'd1, 1'b0);
		offer_request(32'd0, 1'b0, 16'd0, 1'b1);
		drain();

		// Half-way tie: average 0 moved half way toward 1 rounds up
		write_reg(REG_DEFAULT_ALPHA, CFG_DATA_W'(65536));
		offer_request(32'd0, 1'b1, 16'd0, 1'b0);
		offer_request(32'd0, 1'b0, 16'd0, 1'b1);
		drain();
		write_reg(REG_DEFAULT_ALPHA, CFG_DATA_W'(32768));
		offer_request(32'd1, 1'b1, 16'd0, 1'b0);
		offer_request(32'd0, 1'b0, 16'd0, 1'b1);
		drain();

		// Random phases over several register settings
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(phase_window[ph]));
			write_reg(REG_DEFAULT_ALPHA, CFG_DATA_W'(phase_alpha[ph]));
			if (ph == 2) begin
				write_reg(REG_UNUSED_LOW, CFG_DATA_W'($urandom));
				write_reg(REG_UNUSED_HIGH, '1);
			end
			no_gaps = (ph == 3);
			hold_request = (ph == 1);
			done = 0;
			while (done < PHASE_ITEMS) begin
				random_request((ph == 1) ? 45 : 20, counted);
				if (counted) begin
					done++;
				end
			end
			drain();
			no_gaps = 0;
		end

		if (board.mismatches == 0 && board.pending_averages.size() == 0) begin
			$display("All tests passed");
		end else begin
			if (board.pending_averages.size() != 0) begin
				$display("%0d averages never arrived", board.pending_averages.size());
			end
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
